[hdl/rrg_pkg.sv]
package rrg_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_DEGREE   = 8;

    localparam int RAND_W      = 31;
    localparam int QUERY_W     = 6;
    localparam int COUNT_W     = 7;
    localparam int DEG_TGT_W   = 4;
    localparam int DEGREE_W    = 4;
    localparam int POOL_LEFT_W = 10;

    localparam int S_TDATA_W  = 80;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [DEGREE_W-1:0]  DEGREE_CAP        = 4'd15;
    localparam logic [COUNT_W-1:0]   VERTEX_COUNT_RST  = 7'd4;
    localparam logic [DEG_TGT_W-1:0] DEGREE_TARGET_RST = 4'd2;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_TRY   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_VERTEX_COUNT  = 1'b0,
        CFG_DEGREE_TARGET = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[hdl/random_regular_graph_pairing_unit.sv]
// one request at a time; ready is low from acceptance until the result is loaded
// clear: pool memory written one point per cycle
// try: pool scan (one pool read port), then
//   two modulo reductions and the update and swaps, or a degree check
// aresetn is synchronous; after reset, and after each degree_target write, the point
//   divide constant is recomputed before requests are taken
module random_regular_graph_pairing_unit #(
    parameter int MAX_VERTICES = rrg_pkg::DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = rrg_pkg::DEF_MAX_DEGREE
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // random_first, random_second, query_row, query_col
    input  logic [rrg_pkg::S_TDATA_W-1:0]   s_tdata,
    // action
    input  logic [rrg_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pair_accepted, finished, is_regular, edge_bit, row_degree, pool_left
    output logic [rrg_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [rrg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [rrg_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import rrg_pkg::*;

    localparam int POOL_DEPTH = MAX_VERTICES * MAX_DEGREE;
    localparam int PT_W   = $clog2(POOL_DEPTH);
    localparam int PS_W   = $clog2(POOL_DEPTH + 1);
    localparam int VX_W   = $clog2(MAX_VERTICES);
    localparam int NV_W   = $clog2(MAX_VERTICES + 1);
    localparam int KV_W   = $clog2(MAX_DEGREE + 1);
    localparam int SHIFT  = PT_W + $clog2(MAX_DEGREE) + 1;
    localparam int RCP_W  = SHIFT + 1;
    localparam int PROD_W = PT_W + RCP_W;
    localparam int GW     = MAX_VERTICES + DEGREE_W;
    localparam logic [RAND_W-1:0] RECIP_NUM = RAND_W'((64'd1 << SHIFT) - 64'd1);

    typedef enum logic [31:0] {
        ST_RECIP      = 32'd1 << 0,
        ST_RECIP_WAIT = 32'd1 << 1,
        ST_IDLE       = 32'd1 << 2,
        ST_FILL       = 32'd1 << 3,
        ST_READ_RD    = 32'd1 << 4,
        ST_READ_GET   = 32'd1 << 5,
        ST_OUT_RD     = 32'd1 << 6,
        ST_OUT_WAIT   = 32'd1 << 7,
        ST_OUT_VTX    = 32'd1 << 8,
        ST_OUT_ROW    = 32'd1 << 9,
        ST_IN_RUN     = 32'd1 << 10,
        ST_REG_RD     = 32'd1 << 11,
        ST_REG_CHK    = 32'd1 << 12,
        ST_MOD1       = 32'd1 << 13,
        ST_MOD1_WAIT  = 32'd1 << 14,
        ST_MOD2       = 32'd1 << 15,
        ST_MOD2_WAIT  = 32'd1 << 16,
        ST_PT_U       = 32'd1 << 17,
        ST_PT_W       = 32'd1 << 18,
        ST_VTX_U      = 32'd1 << 19,
        ST_VTX_W      = 32'd1 << 20,
        ST_CHK_A      = 32'd1 << 21,
        ST_ROW_B      = 32'd1 << 22,
        ST_WR_B       = 32'd1 << 23,
        ST_SW1_RD     = 32'd1 << 24,
        ST_SW1_WA     = 32'd1 << 25,
        ST_SW1_WB     = 32'd1 << 26,
        ST_SW2_RDJ    = 32'd1 << 27,
        ST_SW2_RDS    = 32'd1 << 28,
        ST_SW2_WJ     = 32'd1 << 29,
        ST_SW2_WS     = 32'd1 << 30,
        ST_DONE       = 32'd1 << 31
    } state_t;

    state_t                  state_reg, state_next;
    logic [COUNT_W-1:0]      vcount_reg, vcount_next;
    logic [DEG_TGT_W-1:0]    dtarget_reg, dtarget_next;
    logic                    kdirty_reg, kdirty_next;
    logic [MAX_VERTICES-1:0] row_valid_reg, row_valid_next;
    logic [PS_W-1:0]         size_reg, size_next;
    logic                    m_valid_reg, m_valid_next;

    logic [PS_W-1:0]         cnt_reg, cnt_next;
    logic [PS_W-1:0]         j_reg, j_next;
    logic                    v1_reg, v1_next, v2_reg, v2_next;
    logic [PT_W-1:0]         idx_i_reg, idx_i_next, idx_j_reg, idx_j_next;
    logic [PT_W-1:0]         u_reg, u_next, tmp_reg, tmp_next;
    logic [PT_W-1:0]         va_reg, va_next, vb_reg, vb_next;
    logic [MAX_VERTICES-1:0] row_reg, row_next;
    logic [RCP_W-1:0]        recip_reg, recip_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [RAND_W-1:0]       r1_reg, r1_next, r2_reg, r2_next;
    logic [QUERY_W-1:0]      qrow_reg, qrow_next, qcol_reg, qcol_next;
    logic                    res_acc_reg, res_acc_next, res_fin_reg, res_fin_next;
    logic                    res_regular_reg, res_regular_next;
    logic                    res_edge_reg, res_edge_next;
    logic [DEGREE_W-1:0]     res_deg_reg, res_deg_next;
    logic [M_TDATA_W-1:0]    m_data_reg, m_data_next;
    logic [VX_W-1:0]         gaddr_d_reg;

    logic                    pool_we;
    logic [PT_W-1:0]         pool_addr, pool_wdata, pool_rdata;
    logic                    graph_we;
    logic [VX_W-1:0]         graph_addr;
    logic [GW-1:0]           graph_wdata, graph_rdata, g_word;
    logic [MAX_VERTICES-1:0] g_row;
    logic [DEGREE_W-1:0]     g_deg;

    logic                    div_start;
    logic [RAND_W-1:0]       div_num;
    logic [PS_W-1:0]         div_den;
    div_status_t             div_status;
    logic [RAND_W-1:0]       div_quo;
    logic [PS_W-1:0]         div_rem;

    logic [NV_W-1:0]         n_eff;
    logic [KV_W-1:0]         k_eff;
    logic [PS_W-1:0]         total;
    logic [PT_W-1:0]         prod_vtx;
    logic                    vtx_lt_n, issue, hit, pair_ok, cfg_k_wr;

    function automatic logic [DEGREE_W-1:0] sat_inc(input logic [DEGREE_W-1:0] d);
        sat_inc = (d == DEGREE_CAP) ? DEGREE_CAP : d + 1'b1;
    endfunction

    rrg_ram #(.WIDTH(PT_W), .DEPTH(POOL_DEPTH)) u_pool_ram (
        .aclk  (aclk),
        .we    (pool_we),
        .addr  (pool_addr),
        .wdata (pool_wdata),
        .rdata (pool_rdata)
    );

    // row word: degree above the adjacency bits
    rrg_ram #(.WIDTH(GW), .DEPTH(MAX_VERTICES)) u_graph_ram (
        .aclk  (aclk),
        .we    (graph_we),
        .addr  (graph_addr),
        .wdata (graph_wdata),
        .rdata (graph_rdata)
    );

    rrg_divider #(.NUM_W(RAND_W), .DEN_W(PS_W)) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_num),
        .divisor   (div_den),
        .status    (div_status),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        if (vcount_reg < COUNT_W'(2)) begin
            n_eff = NV_W'(2);
        end else if (32'(vcount_reg) > MAX_VERTICES) begin
            n_eff = NV_W'(MAX_VERTICES);
        end else begin
            n_eff = NV_W'(vcount_reg);
        end
        if (dtarget_reg == '0) begin
            k_eff = KV_W'(1);
        end else if (32'(dtarget_reg) > MAX_DEGREE) begin
            k_eff = KV_W'(MAX_DEGREE);
        end else begin
            k_eff = KV_W'(dtarget_reg);
        end
    end

    assign total    = PS_W'(n_eff * k_eff);
    assign prod_vtx = prod_reg[SHIFT +: PT_W];
    assign vtx_lt_n = 32'(prod_vtx) < 32'(n_eff);
    assign g_word   = row_valid_reg[gaddr_d_reg] ? graph_rdata : '0;
    assign g_row    = g_word[MAX_VERTICES-1:0];
    assign g_deg    = g_word[GW-1 -: DEGREE_W];
    assign issue    = j_reg < size_reg;
    assign hit      = v2_reg && vtx_lt_n && (prod_vtx != va_reg)
                      && !row_reg[prod_vtx[VX_W-1:0]];
    assign pair_ok  = (32'(va_reg) < 32'(n_eff)) && (32'(vb_reg) < 32'(n_eff))
                      && (va_reg != vb_reg) && !g_row[vb_reg[VX_W-1:0]];
    assign cfg_k_wr = cfg_wr_en && (cfg_addr == CFG_DEGREE_TARGET);
    assign s_tready = (state_reg == ST_IDLE) && !kdirty_reg && !cfg_k_wr;

    always_comb begin
        div_num = r2_reg;
        div_den = size_reg;
        if (state_reg == ST_RECIP) begin
            div_num = RECIP_NUM;
            div_den = PS_W'(k_eff);
        end else if (state_reg == ST_MOD1) begin
            div_num = r1_reg;
        end
    end

    always_comb begin
        state_next       = state_reg;
        vcount_next      = vcount_reg;
        dtarget_next     = dtarget_reg;
        kdirty_next      = kdirty_reg;
        row_valid_next   = row_valid_reg;
        size_next        = size_reg;
        m_valid_next     = m_valid_reg;
        cnt_next         = cnt_reg;
        j_next           = j_reg;
        v1_next          = 1'b0;
        v2_next          = 1'b0;
        idx_i_next       = idx_i_reg;
        idx_j_next       = idx_j_reg;
        u_next           = u_reg;
        tmp_next         = tmp_reg;
        va_next          = va_reg;
        vb_next          = vb_reg;
        row_next         = row_reg;
        recip_next       = recip_reg;
        prod_next        = {{RCP_W{1'b0}}, pool_rdata} * {{PT_W{1'b0}}, recip_reg};
        r1_next          = r1_reg;
        r2_next          = r2_reg;
        qrow_next        = qrow_reg;
        qcol_next        = qcol_reg;
        res_acc_next     = res_acc_reg;
        res_fin_next     = res_fin_reg;
        res_regular_next = res_regular_reg;
        res_edge_next    = res_edge_reg;
        res_deg_next     = res_deg_reg;
        m_data_next      = m_data_reg;
        pool_we          = 1'b0;
        pool_addr        = '0;
        pool_wdata       = '0;
        graph_we         = 1'b0;
        graph_addr       = '0;
        graph_wdata      = '0;
        div_start        = 1'b0;

        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_VERTEX_COUNT: vcount_next = cfg_wr_data;
                CFG_DEGREE_TARGET: begin
                    dtarget_next = cfg_wr_data[DEG_TGT_W-1:0];
                    kdirty_next  = 1'b1;
                end
                default: ;
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_RECIP: begin
                div_start   = 1'b1;
                kdirty_next = cfg_k_wr;
                state_next  = ST_RECIP_WAIT;
            end
            ST_RECIP_WAIT: begin
                if (div_status.done) begin
                    recip_next = RCP_W'(div_quo) + RCP_W'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (kdirty_reg) begin
                    state_next = ST_RECIP;
                end else if (s_tvalid && s_tready) begin
                    r1_next          = s_tdata[30:0];
                    r2_next          = s_tdata[61:31];
                    qrow_next        = s_tdata[67:62];
                    qcol_next        = s_tdata[73:68];
                    res_acc_next     = 1'b0;
                    res_fin_next     = 1'b0;
                    res_regular_next = 1'b0;
                    res_edge_next    = 1'b0;
                    res_deg_next     = '0;
                    cnt_next         = '0;
                    unique case (action_t'(s_tuser))
                        ACT_CLEAR: begin
                            row_valid_next = '0;
                            state_next     = ST_FILL;
                        end
                        ACT_TRY:  state_next = ST_OUT_RD;
                        ACT_READ: state_next = ST_READ_RD;
                        ACT_NOP:  state_next = ST_DONE;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_FILL: begin
                if (cnt_reg == total) begin
                    size_next  = total;
                    state_next = ST_DONE;
                end else begin
                    pool_we    = 1'b1;
                    pool_addr  = cnt_reg[PT_W-1:0];
                    pool_wdata = cnt_reg[PT_W-1:0];
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            ST_READ_RD: begin
                graph_addr = VX_W'(qrow_reg);
                state_next = ST_READ_GET;
            end
            ST_READ_GET: begin
                if (32'(qrow_reg) < MAX_VERTICES) begin
                    res_deg_next = g_deg;
                    if (32'(qcol_reg) < MAX_VERTICES) begin
                        res_edge_next = g_row[VX_W'(qcol_reg)];
                    end
                end
                state_next = ST_DONE;
            end
            // pool scan: outer point
            ST_OUT_RD: begin
                if (cnt_reg == size_reg) begin
                    res_fin_next     = 1'b1;
                    res_regular_next = 1'b1;
                    cnt_next         = '0;
                    state_next       = ST_REG_RD;
                end else begin
                    pool_addr  = cnt_reg[PT_W-1:0];
                    state_next = ST_OUT_WAIT;
                end
            end
            ST_OUT_WAIT: state_next = ST_OUT_VTX;
            ST_OUT_VTX: begin
                va_next = prod_vtx;
                if (vtx_lt_n) begin
                    graph_addr = prod_vtx[VX_W-1:0];
                    state_next = ST_OUT_ROW;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_OUT_RD;
                end
            end
            ST_OUT_ROW: begin
                row_next   = g_row;
                j_next     = '0;
                state_next = ST_IN_RUN;
            end
            // pool scan: inner points, read, scale, check
            ST_IN_RUN: begin
                pool_addr = j_reg[PT_W-1:0];
                if (issue) begin
                    j_next = j_reg + 1'b1;
                end
                v1_next = issue;
                v2_next = v1_reg;
                if (hit) begin
                    v1_next    = 1'b0;
                    v2_next    = 1'b0;
                    state_next = ST_MOD1;
                end else if (!issue && !v1_reg && !v2_reg) begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_OUT_RD;
                end
            end
            ST_REG_RD: begin
                if (32'(cnt_reg) == 32'(n_eff)) begin
                    state_next = ST_DONE;
                end else begin
                    graph_addr = cnt_reg[VX_W-1:0];
                    state_next = ST_REG_CHK;
                end
            end
            ST_REG_CHK: begin
                if (32'(g_deg) != 32'(k_eff)) begin
                    res_regular_next = 1'b0;
                end
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_REG_RD;
            end
            ST_MOD1: begin
                div_start  = 1'b1;
                state_next = ST_MOD1_WAIT;
            end
            ST_MOD1_WAIT: begin
                if (div_status.done) begin
                    idx_i_next = div_rem[PT_W-1:0];
                    state_next = ST_MOD2;
                end
            end
            ST_MOD2: begin
                div_start  = 1'b1;
                state_next = ST_MOD2_WAIT;
            end
            ST_MOD2_WAIT: begin
                if (div_status.done) begin
                    idx_j_next = div_rem[PT_W-1:0];
                    state_next = ST_PT_U;
                end
            end
            ST_PT_U: begin
                pool_addr  = idx_i_reg;
                state_next = ST_PT_W;
            end
            ST_PT_W: begin
                u_next     = pool_rdata;
                pool_addr  = idx_j_reg;
                state_next = ST_VTX_U;
            end
            ST_VTX_U: begin
                va_next    = prod_vtx;
                state_next = ST_VTX_W;
            end
            ST_VTX_W: begin
                vb_next    = prod_vtx;
                graph_addr = va_reg[VX_W-1:0];
                state_next = ST_CHK_A;
            end
            ST_CHK_A: begin
                if (pair_ok) begin
                    graph_we    = 1'b1;
                    graph_addr  = va_reg[VX_W-1:0];
                    graph_wdata = {sat_inc(g_deg),
                                   g_row | (MAX_VERTICES'(1) << vb_reg[VX_W-1:0])};
                    row_valid_next[va_reg[VX_W-1:0]] = 1'b1;
                    state_next  = ST_ROW_B;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_ROW_B: begin
                graph_addr = vb_reg[VX_W-1:0];
                state_next = ST_WR_B;
            end
            ST_WR_B: begin
                graph_we    = 1'b1;
                graph_addr  = vb_reg[VX_W-1:0];
                graph_wdata = {sat_inc(g_deg),
                               g_row | (MAX_VERTICES'(1) << va_reg[VX_W-1:0])};
                row_valid_next[vb_reg[VX_W-1:0]] = 1'b1;
                size_next   = size_reg - 1'b1;
                state_next  = ST_SW1_RD;
            end
            // first point to the pool end
            ST_SW1_RD: begin
                pool_addr  = size_reg[PT_W-1:0];
                state_next = ST_SW1_WA;
            end
            ST_SW1_WA: begin
                pool_we    = 1'b1;
                pool_addr  = idx_i_reg;
                pool_wdata = pool_rdata;
                state_next = ST_SW1_WB;
            end
            ST_SW1_WB: begin
                pool_we    = 1'b1;
                pool_addr  = size_reg[PT_W-1:0];
                pool_wdata = u_reg;
                if (32'(idx_j_reg) == 32'(size_reg)) begin
                    idx_j_next = idx_i_reg;
                end
                size_next  = size_reg - 1'b1;
                state_next = ST_SW2_RDJ;
            end
            // second point to the new pool end
            ST_SW2_RDJ: begin
                pool_addr  = idx_j_reg;
                state_next = ST_SW2_RDS;
            end
            ST_SW2_RDS: begin
                tmp_next   = pool_rdata;
                pool_addr  = size_reg[PT_W-1:0];
                state_next = ST_SW2_WJ;
            end
            ST_SW2_WJ: begin
                pool_we    = 1'b1;
                pool_addr  = idx_j_reg;
                pool_wdata = pool_rdata;
                state_next = ST_SW2_WS;
            end
            ST_SW2_WS: begin
                pool_we      = 1'b1;
                pool_addr    = size_reg[PT_W-1:0];
                pool_wdata   = tmp_reg;
                res_acc_next = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, POOL_LEFT_W'(size_reg), res_deg_reg,
                                    res_edge_reg, res_regular_reg, res_fin_reg,
                                    res_acc_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RECIP;
            vcount_reg    <= VERTEX_COUNT_RST;
            dtarget_reg   <= DEGREE_TARGET_RST;
            kdirty_reg    <= 1'b0;
            row_valid_reg <= '0;
            size_reg      <= '0;
            m_valid_reg   <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            dtarget_reg   <= dtarget_next;
            kdirty_reg    <= kdirty_next;
            row_valid_reg <= row_valid_next;
            size_reg      <= size_next;
            m_valid_reg   <= m_valid_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg         <= cnt_next;
        j_reg           <= j_next;
        idx_i_reg       <= idx_i_next;
        idx_j_reg       <= idx_j_next;
        u_reg           <= u_next;
        tmp_reg         <= tmp_next;
        va_reg          <= va_next;
        vb_reg          <= vb_next;
        row_reg         <= row_next;
        recip_reg       <= recip_next;
        prod_reg        <= prod_next;
        r1_reg          <= r1_next;
        r2_reg          <= r2_next;
        qrow_reg        <= qrow_next;
        qcol_reg        <= qcol_next;
        res_acc_reg     <= res_acc_next;
        res_fin_reg     <= res_fin_next;
        res_regular_reg <= res_regular_next;
        res_edge_reg    <= res_edge_next;
        res_deg_reg     <= res_deg_next;
        m_data_reg      <= m_data_next;
        gaddr_d_reg     <= graph_addr;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(size_reg) <= POOL_DEPTH)
        else $error("pool size beyond capacity");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg[0] && m_data_reg[1]))
        else $error("accepted and finished both set");

    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg != ST_IDLE)
        else $error("request accepted without work");
`endif

endmodule

[hdl/rrg_ram.sv]
module rrg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/rrg_divider.sv]
module rrg_divider #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NUM_W-1:0]     dividend,
    input  logic [DEN_W-1:0]     divisor,
    output rrg_pkg::div_status_t status,
    output logic [NUM_W-1:0]     quotient,
    output logic [DEN_W-1:0]     remainder
);
    import rrg_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg) begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            step_next = STEP_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule
